// ----- hdl/led_blink_pattern_engine_top_assert.svh -----
// Assertion macros shared by the LED blink pattern engine RTL.
`ifndef LED_BLINK_PATTERN_ENGINE_TOP_ASSERT_SVH
`define LED_BLINK_PATTERN_ENGINE_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define LBPE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define LBPE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define LBPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lbpe_pkg.sv -----
// Types and constants of the LED blink pattern engine.
package lbpe_pkg;

	localparam int unsigned PerW  = 16;
	localparam int unsigned RunW  = 20;
	localparam int unsigned AddrW = 3;

	typedef logic [PerW-1:0] per_t;
	typedef logic [RunW-1:0] run_t;

	// Register indexes
	localparam logic [AddrW-1:0] RegSinglePeriod = 3'd0;
	localparam logic [AddrW-1:0] RegSlowPeriod   = 3'd1;
	localparam logic [AddrW-1:0] RegDoubleOn     = 3'd2;
	localparam logic [AddrW-1:0] RegDoubleGap    = 3'd3;
	localparam logic [AddrW-1:0] RegDoubleRest   = 3'd4;
	localparam logic [AddrW-1:0] RegRunTime      = 3'd5;

	// Register reset values
	localparam per_t RstSinglePeriod = 16'd1000;
	localparam per_t RstSlowPeriod   = 16'd2000;
	localparam per_t RstDoubleOn     = 16'd300;
	localparam per_t RstDoubleGap    = 16'd200;
	localparam per_t RstDoubleRest   = 16'd1000;
	localparam run_t RstRunTime      = 20'd60000;

	// Pattern codes
	localparam logic [1:0] PatSingle = 2'd0;
	localparam logic [1:0] PatDouble = 2'd1;
	localparam logic [1:0] PatSlow   = 2'd2;
	localparam logic [1:0] PatBad    = 2'd3;

	// Result status codes
	localparam logic [1:0] StStarted = 2'd0;
	localparam logic [1:0] StBusy    = 2'd1;
	localparam logic [1:0] StBadPat  = 2'd2;
	localparam logic [1:0] StTick    = 2'd3;

	// Double blink phases
	localparam logic [1:0] PhFlash1 = 2'd0;
	localparam logic [1:0] PhGap    = 2'd1;
	localparam logic [1:0] PhFlash2 = 2'd2;
	localparam logic [1:0] PhRest   = 2'd3;

	// Beat kind on the input side
	localparam logic ModeTick  = 1'b0;
	localparam logic ModeStart = 1'b1;

endpackage

// ----- hdl/led_blink_pattern_engine_top.sv -----
// LED blink pattern engine: tick/start beats in, one status beat out per input beat.
//
// Each input beat is a 1 ms tick (s_tuser = 0) or a start command (s_tuser = 1) with
// a pattern code in s_tdata[1:0]: single blink, double blink or slow blink. Every
// input beat produces exactly one output beat with the LED level, a status code and
// the pattern-active flag. The engine takes one beat per clock whenever m_tready is
// high: the state update is a single pass of counter logic from the state registers
// into the result register, which shows the result the cycle after the beat is taken;
// s_tready drops only while the result register is full and m_tready is low. Configuration is
// written through cfg_we/cfg_addr/cfg_wdata while the engine is idle; the user must keep to
// this, the block does not enforce it. A value of zero acts as one; indexes above five are ignored.
module led_blink_pattern_engine_top
	import lbpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [1:0] pattern_code, [7:2] zero
	input  logic             s_tuser,   // [0] mode
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [0] led_on, [2:1] status, [3] pattern_active, [7:4] zero
	// configuration writes
	input  logic             cfg_we,
	input  logic [AddrW-1:0] cfg_addr,
	input  logic [RunW-1:0]  cfg_wdata
);

	// Configuration registers, held with zero already mapped to one
	per_t single_per_q, slow_per_q, dbl_on_q, dbl_gap_q, dbl_rest_q;
	run_t run_time_q;

	// Engine state
	logic       active_q, run_flag_q, led_q;
	logic [1:0] pattern_q, phase_q;
	per_t       wait_q;
	run_t       run_cnt_q;

	// Result register
	logic       out_valid_q;
	logic [3:0] out_data_q;

	// Next-state values
	logic       active_d, run_flag_d, led_d;
	logic [1:0] pattern_d, phase_d, status_d;
	per_t       wait_d, cfg_per;
	run_t       run_cnt_d, cfg_run;

	logic s_accept;

	assign s_tready = !out_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_data_q};

	assign cfg_per = (cfg_wdata[PerW-1:0] == '0) ? per_t'(1) : cfg_wdata[PerW-1:0];
	assign cfg_run = (cfg_wdata == '0) ? run_t'(1) : cfg_wdata;

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_per_q <= RstSinglePeriod;
			slow_per_q   <= RstSlowPeriod;
			dbl_on_q     <= RstDoubleOn;
			dbl_gap_q    <= RstDoubleGap;
			dbl_rest_q   <= RstDoubleRest;
			run_time_q   <= RstRunTime;
		end else if (cfg_we) begin
			case (cfg_addr)
				RegSinglePeriod: single_per_q <= cfg_per;
				RegSlowPeriod:   slow_per_q   <= cfg_per;
				RegDoubleOn:     dbl_on_q     <= cfg_per;
				RegDoubleGap:    dbl_gap_q    <= cfg_per;
				RegDoubleRest:   dbl_rest_q   <= cfg_per;
				RegRunTime:      run_time_q   <= cfg_run;
				default: ;
			endcase
		end
	end

	// Single-pass state update for one beat
	always_comb begin
		active_d   = active_q;
		run_flag_d = run_flag_q;
		led_d      = led_q;
		pattern_d  = pattern_q;
		phase_d    = phase_q;
		wait_d     = wait_q;
		run_cnt_d  = run_cnt_q;
		status_d   = StTick;

		if (s_tuser == ModeStart) begin
			if (active_q) begin
				status_d = StBusy;
			end else if (s_tdata[1:0] == PatBad) begin
				status_d = StBadPat;
			end else begin
				status_d   = StStarted;
				active_d   = 1'b1;
				run_flag_d = 1'b1;
				run_cnt_d  = run_time_q;
				pattern_d  = s_tdata[1:0];
				phase_d    = PhFlash1;
				if (s_tdata[1:0] == PatDouble) begin
					led_d  = 1'b1;
					wait_d = dbl_on_q;
				end else begin
					// first toggle happens at once: LED reads off
					led_d  = 1'b0;
					wait_d = (s_tdata[1:0] == PatSlow) ? slow_per_q : single_per_q;
				end
			end
		end else begin
			// run counter first
			if (run_flag_q) begin
				if (run_cnt_q <= run_t'(1)) begin
					run_flag_d = 1'b0;
					run_cnt_d  = '0;
				end else begin
					run_cnt_d = run_cnt_q - run_t'(1);
				end
			end
			// then the pattern wait, which sees the updated run flag
			if (active_q) begin
				if (wait_q <= per_t'(1)) begin
					if (pattern_q != PatDouble || phase_q == PhRest) begin
						if (!run_flag_d) begin
							// loop check failed: wind down
							led_d    = 1'b0;
							active_d = 1'b0;
							phase_d  = PhFlash1;
							wait_d   = '0;
						end else if (pattern_q != PatDouble) begin
							led_d  = !led_q;
							wait_d = (pattern_q == PatSlow) ? slow_per_q : single_per_q;
						end else begin
							led_d   = 1'b1;
							phase_d = PhFlash1;
							wait_d  = dbl_on_q;
						end
					end else begin
						case (phase_q)
							PhFlash1: begin
								led_d   = 1'b0;
								phase_d = PhGap;
								wait_d  = dbl_gap_q;
							end
							PhGap: begin
								led_d   = 1'b1;
								phase_d = PhFlash2;
								wait_d  = dbl_on_q;
							end
							default: begin
								led_d   = 1'b0;
								phase_d = PhRest;
								wait_d  = dbl_rest_q;
							end
						endcase
					end
				end else begin
					wait_d = wait_q - per_t'(1);
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			run_flag_q <= 1'b0;
			led_q      <= 1'b0;
			pattern_q  <= PatSingle;
			phase_q    <= PhFlash1;
			wait_q     <= '0;
			run_cnt_q  <= '0;
		end else if (s_accept) begin
			active_q   <= active_d;
			run_flag_q <= run_flag_d;
			led_q      <= led_d;
			pattern_q  <= pattern_d;
			phase_q    <= phase_d;
			wait_q     <= wait_d;
			run_cnt_q  <= run_cnt_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_data_q <= {active_d, status_d, led_d};
		end
	end

	`include "led_blink_pattern_engine_top_assert.svh"

	`LBPE_ASSERT_IMPL(a_led_off_idle, !active_q, !led_q, "LED lit while idle")
	`LBPE_ASSERT_IMPL(a_run_needs_active, run_flag_q, active_q, "run flag set while idle")
	`LBPE_ASSERT_IMPL(a_wait_nonzero, active_q, wait_q != '0, "active with zero wait")
	`LBPE_ASSERT_IMPL(a_phase_double, phase_q != PhFlash1, pattern_q == PatDouble, "phase moved outside double blink")
	`LBPE_ASSERT_NEXT(a_start_runs, s_accept && s_tuser == ModeStart && !active_q && s_tdata[1:0] != PatBad, active_q && run_flag_q, "valid start did not activate")

endmodule

// ----- dv/led_blink_pattern_engine_top_tb.sv -----
// Self-checking stream testbench for the LED blink pattern engine.
module led_blink_pattern_engine_top_tb;
	import lbpe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 400000;
	localparam int MaxErrLines = 100;

	// Register slots past the last one; writes there must be ignored
	localparam logic [AddrW-1:0] RegSpareLo = 3'd6;
	localparam logic [AddrW-1:0] RegSpareHi = 3'd7;

	typedef struct packed {
		logic       mode;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic       led;
		logic [1:0] status;
		logic       act;
	} blink_res_t;

	// Bits above a narrow register's width
	typedef logic [RunW-PerW-1:0] junk_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;    // [1:0] pattern_code, [7:2] zero
	logic             s_tuser = 1'b0;  // [0] mode
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;         // [0] led_on, [2:1] status, [3] pattern_active
	logic             cfg_we = 1'b0;
	logic [AddrW-1:0] cfg_addr = '0;
	logic [RunW-1:0]  cfg_wdata = '0;

	cmd_t       cmd_q[$];
	blink_res_t led_status_q[$];
	int         src_idle = 0;
	int         snk_idle = 0;
	int         err_cnt = 0;
	int         cycle_cnt = 0;
	int         pushed = 0;

	// Predictor copy of configuration and engine state
	per_t       cfg_single = RstSinglePeriod;
	per_t       cfg_slow   = RstSlowPeriod;
	per_t       cfg_on     = RstDoubleOn;
	per_t       cfg_gap    = RstDoubleGap;
	per_t       cfg_rest   = RstDoubleRest;
	run_t       cfg_run    = RstRunTime;
	logic       active_m = 1'b0;
	logic       run_flag_m = 1'b0;
	logic [1:0] pat_m = PatSingle;
	logic [1:0] phase_m = PhFlash1;
	per_t       wait_m = '0;
	run_t       run_m = '0;
	logic       led_m = 1'b0;

	led_blink_pattern_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Zero intervals behave as one tick
	function per_t floor_one(per_t v);
		return (v == '0) ? per_t'(1) : v;
	endfunction

	// Loop check: stop the pattern once the run flag has cleared
	function bit loop_check();
		if (!run_flag_m) begin
			led_m = 1'b0;
			active_m = 1'b0;
			phase_m = PhFlash1;
			wait_m = '0;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function void toggle_step();
		if (loop_check()) begin
			led_m = !led_m;
			wait_m = floor_one(pat_m == PatSlow ? cfg_slow : cfg_single);
		end
	endfunction

	function void flash_begin();
		led_m = 1'b1;
		phase_m = PhFlash1;
		wait_m = floor_one(cfg_on);
	endfunction

	function void wake();
		if (pat_m != PatDouble) begin
			toggle_step();
		end else begin
			case (phase_m)
				PhFlash1: begin
					led_m = 1'b0;
					phase_m = PhGap;
					wait_m = floor_one(cfg_gap);
				end
				PhGap: begin
					led_m = 1'b1;
					phase_m = PhFlash2;
					wait_m = floor_one(cfg_on);
				end
				PhFlash2: begin
					led_m = 1'b0;
					phase_m = PhRest;
					wait_m = floor_one(cfg_rest);
				end
				default: begin
					if (loop_check())
						flash_begin();
				end
			endcase
		end
	endfunction

	// Advance the predicted engine by one input beat
	function blink_res_t blink_step(logic mode, logic [1:0] code);
		blink_res_t r;
		if (mode == ModeStart) begin
			if (active_m) begin
				r.status = StBusy;
			end else if (code == PatBad) begin
				r.status = StBadPat;
			end else begin
				r.status = StStarted;
				active_m = 1'b1;
				run_flag_m = 1'b1;
				run_m = (cfg_run == '0) ? run_t'(1) : cfg_run;
				pat_m = code;
				phase_m = PhFlash1;
				led_m = 1'b1;
				if (pat_m == PatDouble)
					flash_begin();
				else
					toggle_step();
			end
		end else begin
			r.status = StTick;
			// run counter first, pattern wait second
			if (run_flag_m) begin
				if (run_m <= 1) begin
					run_flag_m = 1'b0;
					run_m = '0;
				end else begin
					run_m = run_m - 1'b1;
				end
			end
			if (active_m) begin
				if (wait_m <= 1)
					wake();
				else
					wait_m = wait_m - 1'b1;
			end
		end
		r.led = led_m;
		r.act = active_m;
		return r;
	endfunction

	task report_mismatch(input string msg);
		if (err_cnt < MaxErrLines)
			$display("%0t ns mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	task push_item(input logic mode, input logic [1:0] code);
		cmd_t c;
		c.mode = mode;
		c.code = code;
		cmd_q.push_back(c);
		pushed++;
	endtask

	// One register write; predictor copy follows with the same masking
	task write_reg(input logic [AddrW-1:0] idx, input run_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			RegSinglePeriod: cfg_single = val[PerW-1:0];
			RegSlowPeriod:   cfg_slow   = val[PerW-1:0];
			RegDoubleOn:     cfg_on     = val[PerW-1:0];
			RegDoubleGap:    cfg_gap    = val[PerW-1:0];
			RegDoubleRest:   cfg_rest   = val[PerW-1:0];
			RegRunTime:      cfg_run    = val;
			default: ;
		endcase
	endtask

	// Write every register, with junk above bit 15 of the narrow ones
	task set_regs(input per_t sp, input per_t sl, input per_t on, input per_t gp,
			input per_t rs, input run_t rt);
		junk_t junk;
		junk = junk_t'($urandom);
		write_reg(RegSinglePeriod, {junk, sp});
		junk = junk_t'($urandom);
		write_reg(RegSlowPeriod, {junk, sl});
		junk = junk_t'($urandom);
		write_reg(RegDoubleOn, {junk, on});
		junk = junk_t'($urandom);
		write_reg(RegDoubleGap, {junk, gp});
		junk = junk_t'($urandom);
		write_reg(RegDoubleRest, {junk, rs});
		write_reg(RegRunTime, rt);
		write_reg(RegSpareLo, run_t'($urandom));
		write_reg(RegSpareHi, run_t'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every beat is out and checked, then a little slack
	task wait_drained();
		while (cmd_q.size() != 0 || s_tvalid || led_status_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Input driver: predicts on each accepted beat, then loads the next one
	always @(posedge clk) begin : drive_proc
		cmd_t c;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				led_status_q.push_back(blink_step(s_tuser, s_tdata[1:0]));
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
					c = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= c.mode;
					s_tdata <= {6'b0, c.code};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and receiver backpressure
	always @(posedge clk) begin : mon_proc
		blink_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (led_status_q.size() == 0) begin
				report_mismatch($sformatf("result beat 0x%02h with nothing pending", m_tdata));
			end else begin
				want = led_status_q.pop_front();
				if (m_tdata[0] !== want.led)
					report_mismatch($sformatf("led_on %b, want %b", m_tdata[0], want.led));
				if (m_tdata[2:1] !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						m_tdata[2:1], want.status));
				if (m_tdata[3] !== want.act)
					report_mismatch($sformatf("pattern_active %b, want %b",
						m_tdata[3], want.act));
			end
		end
		m_tready <= ($urandom_range(0, 99) >= snk_idle);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : stim_proc
		int sp, sl, on, gp, rs, rt, top, k, goal;
		src_idle = 22;
		snk_idle = 62;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Idle engine: tick and unsupported code need no configuration
		push_item(ModeTick, PatSingle);
		push_item(ModeStart, PatBad);
		wait_drained();

		// Short intervals so every pattern runs to completion
		set_regs(16'd0, 16'd2, 16'd1, 16'd2, 16'd1, 20'd3);
		push_item(ModeStart, PatSingle);
		push_item(ModeStart, PatSingle);   // refused, busy
		repeat (4) push_item(ModeTick, PatSingle);
		push_item(ModeStart, PatSlow);
		push_item(ModeStart, PatBad);      // busy wins over bad code
		repeat (6) push_item(ModeTick, PatSingle);
		push_item(ModeStart, PatDouble);
		repeat (3) push_item(ModeTick, PatSingle);
		push_item(ModeStart, PatDouble);   // refused during wind-down
		repeat (3) push_item(ModeTick, PatSingle);

		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			src_idle = (ph < 4) ? 22 : ((ph < 8) ? 62 : 0);
			snk_idle = (ph < 4) ? 62 : ((ph < 8) ? 22 : 0);
			if (ph == 11) begin
				// widest values; patterns never finish here
				sp = 65535; sl = 65535; on = 65535; gp = 65535; rs = 65535;
				rt = 20'hFFFFF;
			end else if (ph == 5) begin
				sp = 0; sl = 0; on = 0; gp = 0; rs = 0; rt = 0;
			end else begin
				sp = $urandom_range(0, 6);
				sl = $urandom_range(0, 6);
				on = $urandom_range(0, 6);
				gp = $urandom_range(0, 6);
				rs = $urandom_range(0, 6);
				rt = $urandom_range(0, 40);
			end
			set_regs(per_t'(sp), per_t'(sl), per_t'(on), per_t'(gp), per_t'(rs), run_t'(rt));
			top = 2 * rt + 4 * (sp + sl + on + gp + rs) + 6;
			if (top > 60)
				top = 60;
			goal = pushed + ((ph == 11) ? 50 : 100);
			while (pushed < goal) begin
				if ($urandom_range(0, 99) < 75) begin
					// start followed by a run of ticks, rare stray starts inside
					if ($urandom_range(0, 9) == 0)
						push_item(ModeStart, PatBad);
					else
						push_item(ModeStart, 2'($urandom_range(0, 2)));
					k = $urandom_range(1, top);
					for (int j = 0; j < k && pushed < goal; j++) begin
						if ($urandom_range(0, 19) == 0)
							push_item(ModeStart, 2'($urandom_range(0, 3)));
						else
							push_item(ModeTick, 2'($urandom_range(0, 3)));
					end
				end else begin
					push_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
				end
			end
		end

		wait_drained();
		if (led_status_q.size() != 0)
			report_mismatch("results still pending at end of run");
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
